>>> src/sspw_pkg.sv
// Shared constants, types and helpers for the spaced seed period/weight core.
// No dependencies; every other file in src uses this package.
`timescale 1ns / 1ps

package sspw_pkg;

  localparam int SEED_BITS = 64;   // active seed width, 8..64
  localparam int IN_W      = 64;   // seed field width on the channel
  localparam int PER_W     = 6;    // best_period width
  localparam int WGT_W     = 7;    // periodic_weight width

  // popcount of the top bits is split into byte groups
  localparam int GRP_BITS  = 8;
  localparam int GROUPS    = (SEED_BITS + GRP_BITS - 1) / GRP_BITS;
  localparam int PAD_BITS  = GROUPS * GRP_BITS;
  localparam int GCNT_W    = $clog2(GRP_BITS + 1);

  // min search: leaf 0 is the no-period default, leaf p is shift p
  localparam int LEAVES    = 64;
  localparam int FAN       = 8;
  localparam int MID       = LEAVES / FAN;

  typedef logic [SEED_BITS-1:0] pat_t;
  typedef logic [GCNT_W-1:0]    gcnt_t;

  typedef struct packed {
    pat_t x;   // masked seed
    pat_t t;   // t[i] = 1 when some set bit is at or above i
  } span_t;

  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [WGT_W-1:0] weight;
  } cand_t;

  typedef cand_t [LEAVES-1:0] cand_vec_t;

  localparam cand_t NO_PERIOD = '{period: '0, weight: WGT_W'(SEED_BITS)};

  function automatic gcnt_t grp_ones(logic [GRP_BITS-1:0] v);
    gcnt_t c;
    c = '0;
    for (int i = 0; i < GRP_BITS; i++) begin
      c = c + gcnt_t'(v[i]);
    end
    return c;
  endfunction

endpackage

>>> src/sspw_if.sv
// Valid/ready channel interfaces for seeds in and results out.
// Depends on sspw_pkg for field widths.
`timescale 1ns / 1ps

interface sspw_seed_if;
  logic                        valid;
  logic                        ready;
  logic [sspw_pkg::IN_W-1:0]   seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

interface sspw_res_if;
  logic                        valid;
  logic                        ready;
  logic [sspw_pkg::PER_W-1:0]  best_period;
  logic [sspw_pkg::WGT_W-1:0]  periodic_weight;

  modport source (output valid, output best_period, output periodic_weight, input ready);
  modport sink   (input valid, input best_period, input periodic_weight, output ready);
endinterface

>>> src/spaced_seed_period_weight_core.sv
// Spaced seed period/weight core: top level.
// Depends on sspw_pkg, sspw_if, sspw_span, sspw_shift_check, sspw_min_tree.
//
// Usage:
//   seed_i carries one seed item per valid/ready handshake; res_o returns
//   one result item (best_period, periodic_weight) per seed, in order.
//   Only the low SEED_BITS bits of a seed are looked at.
//   There are six register stages (masking, span smear, shift test with
//   byte popcounts, weight sums, first min level, final min/output), and
//   the first one loads at the accepting edge.
//   Throughput: one item per cycle while res_o.ready holds; every shift is
//   tested in parallel, so the six-stage pipeline itself sets the rate.
//   Stall: each stage holds its item while the stage after it is full and
//   blocked; ready propagates back stage by stage, so up to six items sit
//   in flight and none is dropped or repeated.
//   Reset (rst_ni low, asynchronous): all stage valid bits clear; the
//   block keeps no other state and is ready right after reset.
`timescale 1ns / 1ps

module spaced_seed_period_weight_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  sspw_seed_if.sink    seed_i,
  sspw_res_if.source   res_o
);
  import sspw_pkg::*;

  // span stage -> shift check
  logic      span_valid, span_ready;
  span_t     span;

  // shift check -> min search
  logic      cand_valid, cand_ready;
  cand_vec_t cand;

  cand_t     res;

  sspw_span u_span (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seed_i.valid),
    .ready_o (seed_i.ready),
    .seed_i  (seed_i.seed),
    .valid_o (span_valid),
    .ready_i (span_ready),
    .span_o  (span)
  );

  sspw_shift_check u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (span_valid),
    .ready_o (span_ready),
    .span_i  (span),
    .valid_o (cand_valid),
    .ready_i (cand_ready),
    .cand_o  (cand)
  );

  // final stage doubles as the output register
  sspw_min_tree u_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cand_valid),
    .ready_o (cand_ready),
    .cand_i  (cand),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (res)
  );

  assign res_o.best_period     = res.period;
  assign res_o.periodic_weight = res.weight;

endmodule

>>> src/sspw_span.sv
// Stages 1-2: mask the seed to SEED_BITS, then smear set bits downward
// to get the span thermometer. Depends on sspw_pkg.
`timescale 1ns / 1ps

module sspw_span (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [sspw_pkg::IN_W-1:0] seed_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output sspw_pkg::span_t           span_o
);
  import sspw_pkg::*;

  logic  va_q, vb_q;
  logic  rdy_a, rdy_b;
  pat_t  xa_q;
  span_t sb_d, sb_q;

  assign rdy_b   = !vb_q || ready_i;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  // bits above the seed width drop out here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (rdy_a) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_a) begin
      xa_q <= seed_i[SEED_BITS-1:0];
    end
  end

  // log-step prefix OR from the top
  always_comb begin
    pat_t t;
    t = xa_q;
    for (int k = 1; k < SEED_BITS; k = k * 2) begin
      t = t | (t >> k);
    end
    sb_d.x = xa_q;
    sb_d.t = t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (rdy_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (va_q && rdy_b) begin
      sb_q <= sb_d;
    end
  end

  assign valid_o = vb_q;
  assign span_o  = sb_q;

endmodule

>>> src/sspw_shift_check.sv
// Stages 3-4: per-shift periodicity test and byte-group popcounts of the
// top bits, then per-shift weight sums into candidates. Depends on sspw_pkg.
`timescale 1ns / 1ps

module sspw_shift_check (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  sspw_pkg::span_t       span_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output sspw_pkg::cand_vec_t   cand_o
);
  import sspw_pkg::*;

  logic      vc_q, vd_q;
  logic      rdy_c, rdy_d;
  logic      hold_d  [1:SEED_BITS-1];
  logic      hold_q  [1:SEED_BITS-1];
  gcnt_t     parts_d [1:SEED_BITS-1][GROUPS];
  gcnt_t     parts_q [1:SEED_BITS-1][GROUPS];
  cand_vec_t cand_d, cand_q;

  assign rdy_d   = !vd_q || ready_i;
  assign rdy_c   = !vc_q || rdy_d;
  assign ready_o = rdy_c;

  // shift p holds when x[i] == x[i+p] for all i with i+p below the span;
  // t >> p marks exactly those positions
  always_comb begin
    pat_t                msk;
    pat_t                top;
    logic [PAD_BITS-1:0] topx;
    for (int p = 1; p < SEED_BITS; p++) begin
      msk        = span_i.t >> p;
      hold_d[p]  = span_i.t[p] && (((span_i.x ^ (span_i.x >> p)) & msk) == '0);
      top        = span_i.x & ~msk;
      topx       = PAD_BITS'(top);
      for (int g = 0; g < GROUPS; g++) begin
        parts_d[p][g] = grp_ones(topx[g*GRP_BITS +: GRP_BITS]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_c) begin
      hold_q  <= hold_d;
      parts_q <= parts_d;
    end
  end

  // failing shifts and unused leaves carry the no-period default
  always_comb begin
    logic [WGT_W-1:0] sum;
    for (int l = 0; l < LEAVES; l++) begin
      cand_d[l] = NO_PERIOD;
    end
    for (int p = 1; p < SEED_BITS; p++) begin
      sum = '0;
      for (int g = 0; g < GROUPS; g++) begin
        sum = sum + WGT_W'(parts_q[p][g]);
      end
      if (hold_q[p]) begin
        cand_d[p].period = PER_W'(p);
        cand_d[p].weight = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (rdy_d) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vc_q && rdy_d) begin
      cand_q <= cand_d;
    end
  end

  assign valid_o = vd_q;
  assign cand_o  = cand_q;

endmodule

>>> src/sspw_min_tree.sv
// Stages 5-6: two-level min search over the candidates, first leaf wins
// on ties. Stage 6 is the output register. Depends on sspw_pkg.
`timescale 1ns / 1ps

module sspw_min_tree (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  sspw_pkg::cand_vec_t   cand_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output sspw_pkg::cand_t       res_o
);
  import sspw_pkg::*;

  logic  ve_q, vf_q;
  logic  rdy_e, rdy_f;
  cand_t mid_d [MID];
  cand_t mid_q [MID];
  cand_t res_d, res_q;

  assign rdy_f   = !vf_q || ready_i;
  assign rdy_e   = !ve_q || rdy_f;
  assign ready_o = rdy_e;

  // strict less keeps the lower shift on equal weight
  always_comb begin
    cand_t best;
    for (int m = 0; m < MID; m++) begin
      best = cand_i[m*FAN];
      for (int j = 1; j < FAN; j++) begin
        if (cand_i[m*FAN+j].weight < best.weight) begin
          best = cand_i[m*FAN+j];
        end
      end
      mid_d[m] = best;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (rdy_e) begin
      ve_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_e) begin
      mid_q <= mid_d;
    end
  end

  always_comb begin
    res_d = mid_q[0];
    for (int m = 1; m < MID; m++) begin
      if (mid_q[m].weight < res_d.weight) begin
        res_d = mid_q[m];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (rdy_f) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ve_q && rdy_f) begin
      res_q <= res_d;
    end
  end

  assign valid_o = vf_q;
  assign res_o   = res_q;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for spaced_seed_period_weight_core: a directed table, then random seeds.
// Depends on sspw_pkg, sspw_if and the core RTL; an in-bench period/weight predictor checks results.
`timescale 1ns / 1ps

module tb_top;
  import sspw_pkg::*;

  localparam int CLK_HALF     = 10;      // 20 ns period
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 12;      // twice the six-stage pipeline depth
  localparam int HOLD_CYCLES  = 120;     // long receiver hold-off in the pressure phase
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int REPORT_MAX   = 10;

  // one directed item: seed, whether a hand-typed result is given, and that result
  typedef struct packed {
    logic [IN_W-1:0] seed;
    logic            typed;
    cand_t           want;
  } dir_row_t;

  localparam int DIR_N = 21;
  localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
    // zero seed: no span at all
    '{64'h0000_0000_0000_0000, 1'b1, NO_PERIOD},
    // single-bit span: no shift to try
    '{64'h0000_0000_0000_0001, 1'b1, NO_PERIOD},
    // two-bit span, shift 1 fails
    '{64'h0000_0000_0000_0002, 1'b1, NO_PERIOD},
    '{64'h0000_0000_0000_0003, 1'b1, '{period: 6'd1,  weight: 7'd1}},
    '{64'h0000_0000_0000_0005, 1'b1, '{period: 6'd2,  weight: 7'd1}},
    '{64'h0000_0000_0000_0009, 1'b1, '{period: 6'd3,  weight: 7'd1}},
    // full-width extremes
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{period: 6'd1,  weight: 7'd1}},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{period: 6'd1,  weight: 7'd1}},
    '{64'h8000_0000_0000_0001, 1'b1, '{period: 6'd63, weight: 7'd1}},
    '{64'h8000_0000_0000_0000, 1'b1, NO_PERIOD},
    '{64'h4000_0000_0000_0000, 1'b1, NO_PERIOD},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, NO_PERIOD},
    '{64'h5555_5555_5555_5555, 1'b1, '{period: 6'd2,  weight: 7'd1}},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{period: 6'd2,  weight: 7'd1}},
    '{64'h0000_0001_0000_0001, 1'b1, '{period: 6'd32, weight: 7'd1}},
    // the rest go through the predictor: ties between shifts, multi-period words
    '{64'hB6DB_6DB6_DB6D_B6DB, 1'b0, NO_PERIOD},
    '{64'h0123_4567_89AB_CDEF, 1'b0, NO_PERIOD},
    '{64'hFFFF_0000_FFFF_0000, 1'b0, NO_PERIOD},
    '{64'hDEAD_BEEF_DEAD_BEEF, 1'b0, NO_PERIOD},
    '{64'h0000_0000_0000_00ED, 1'b0, NO_PERIOD},
    '{64'h8000_0000_0000_0003, 1'b0, NO_PERIOD}
  };

  logic clk = 1'b0;
  logic rst_n;

  // idling knobs and pressure control; all written with NBAs at the clock edge
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  logic hold_req      = 1'b0;
  logic hold_on       = 1'b0;

  // bookkeeping
  cand_t expected_results[$];
  int    mismatches     = 0;
  int    seeds_sent     = 0;
  int    results_seen   = 0;
  int    periodic_seen  = 0;
  int    input_stalls   = 0;
  int    cycles         = 0;

  sspw_seed_if seed_ch ();
  sspw_res_if  res_ch ();

  spaced_seed_period_weight_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seed_i (seed_ch.sink),
    .res_o  (res_ch.source)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor. Mask to the active width, find the span h, then try every
  // shift p below h: it holds when the low h-p bits match the seed shifted
  // down by p. Keep the holding shift with the fewest set bits in its top
  // p bits, first one wins on a tie.
  function automatic cand_t period_weight_of(input logic [IN_W-1:0] raw);
    logic [63:0] x;
    logic [63:0] low_mask;
    int          h;
    int          w;
    cand_t       best;
    x    = 64'(raw) & ({64{1'b1}} >> (64 - SEED_BITS));
    h    = 0;
    best = NO_PERIOD;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) h = i + 1;
    end
    for (int p = 1; p < h; p++) begin
      low_mask = {64{1'b1}} >> (64 - (h - p));
      if (((x ^ (x >> p)) & low_mask) == 64'd0) begin
        w = $countones(x >> (h - p));
        if (w < int'(best.weight)) begin
          best.weight = WGT_W'(w);
          best.period = PER_W'(p);
        end
      end
    end
    return best;
  endfunction

  // Random seeds. Most are periodic words (a short base pattern repeated up
  // to a random span, sometimes sparse, sometimes with one bit broken), so
  // many shifts hold and the min search gets real work. The rest: raw
  // 64-bit noise, a few scattered bits, or noise cut to a random width.
  function automatic logic [IN_W-1:0] make_seed();
    logic [63:0] x;
    logic [63:0] base;
    int          shape;
    int          span;
    int          rep;
    int          nbits;
    int          flip;
    shape = $urandom_range(0, 9);
    base  = {$urandom, $urandom};
    x     = '0;
    if (shape <= 5) begin
      span = $urandom_range(2, 64);
      rep  = $urandom_range(0, 1) ? $urandom_range(1, (span < 8) ? span : 8)
                                  : $urandom_range(1, span);
      if ($urandom_range(0, 1)) base = base & {$urandom, $urandom};
      base[(span - 1) % rep] = 1'b1;   // keep the span's top bit set
      for (int i = 0; i < span; i++) begin
        x[i] = base[i % rep];
      end
      if ($urandom_range(0, 4) == 0) begin
        flip    = $urandom_range(0, span - 1);
        x[flip] = ~x[flip];
      end
    end else if (shape <= 7) begin
      x = base;
    end else if (shape == 8) begin
      nbits = $urandom_range(1, 4);
      for (int i = 0; i < nbits; i++) begin
        x[$urandom_range(0, 63)] = 1'b1;
      end
    end else begin
      x = base >> $urandom_range(0, 63);
    end
    return IN_W'(x);
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t ns: %s", $time, msg);
  endfunction

  // Offer one seed and return right after the edge that accepts it. Valid
  // stays high into the next call unless that call starts with idle cycles,
  // so back-to-back items never see valid dropped and raised in one step.
  task automatic push_seed(input logic [IN_W-1:0] s, input logic typed, input cand_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      seed_ch.valid <= 1'b0;
      seed_ch.seed  <= {$urandom, $urandom};
      @(posedge clk);
    end
    seed_ch.valid <= 1'b1;
    seed_ch.seed  <= s;
    @(posedge clk);
    while (!seed_ch.ready) @(posedge clk);
    expected_results.push_back(typed ? want : period_weight_of(s));
    seeds_sent++;
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    src_idle_pct  <= idle_pct;
    snk_stall_pct <= stall_pct;
    for (int n = 0; n < count; n++) begin
      push_seed(make_seed(), 1'b0, NO_PERIOD);
    end
  endtask

  // Result side: compare every accepted result against the oldest
  // expectation, then pick ready for the next cycle.
  initial begin : result_side
    cand_t want;
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (res_ch.best_period != '0) periodic_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result period=%0d weight=%0d",
                                    res_ch.best_period, res_ch.periodic_weight));
        end else begin
          want = expected_results.pop_front();
          if (res_ch.best_period !== want.period || res_ch.periodic_weight !== want.weight) begin
            report_mismatch($sformatf("result %0d: expected period=%0d weight=%0d, got %0d/%0d",
                                      results_seen, want.period, want.weight,
                                      res_ch.best_period, res_ch.periodic_weight));
          end
        end
      end
      res_ch.ready <= !hold_on && ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Long receiver hold-off, timed here, so the pipeline fills and back-pressures
  initial begin : hold_off
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Cycle count, input stall count, and the watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (seed_ch.valid && !seed_ch.ready) input_stalls <= input_stalls + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n          = 1'b0;
    seed_ch.valid <= 1'b0;
    seed_ch.seed  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int r = 0; r < DIR_N; r++) begin
      push_seed(DIR_ROWS[r].seed, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    // random phases: free-running, sparse sender, slow receiver, light both
    run_random(450, 0, 0);
    run_random(400, 70, 0);
    run_random(400, 0, 70);
    run_random(450, 10, 10);

    // pressure: receiver holds off while the sender keeps offering
    hold_req <= 1'b1;
    run_random(150, 0, 0);

    seed_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d seeds through %0d cycles, %0d results checked, %0d with a period found",
             seeds_sent, cycles, results_seen, periodic_seen);
    $display("%0d cycles with the input held off, %0d mismatches", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
